@@ hdl/cvet_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants, sine table and fixed-point helpers for the cube vertex transform
package cvet_pkg;

	// wide coordinate carried through the rotation chain, Q4.12 with headroom
	localparam int CoordW   = 19;
	// sine and cosine, signed Q1.14
	localparam int TrigW    = 16;
	localparam int TrigFrac = 14;
	localparam int ProdW    = CoordW + TrigW;

	// angle reduction: biased sum, reciprocal multiply, remainder in 0..359
	localparam int AngW       = 9;
	localparam int BiasW      = 18;
	localparam int RecipShift = 26;
	localparam logic [BiasW-1:0] AngleBias = 18'd65880;   // 183 full turns
	localparam logic [BiasW-1:0] RecipMul  = 18'd186414;  // ceil(2^26 / 360)
	localparam logic [BiasW-1:0] FullTurnB = 18'd360;

	localparam logic [AngW-1:0] QuarterTurn = 9'd90;
	localparam logic [AngW-1:0] HalfTurn    = 9'd180;
	localparam logic [AngW-1:0] ThreeQuart  = 9'd270;
	localparam logic [AngW-1:0] FullTurn    = 9'd360;

	localparam int QueueDepth = 2;

	typedef logic signed [15:0]      word_t;
	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [TrigW-1:0]  trig_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [ProdW:0]    acc_t;

	typedef enum logic [2:0] {
		RegOffsetX    = 3'd0,
		RegOffsetY    = 3'd1,
		RegOffsetZ    = 3'd2,
		RegExtraTurnY = 3'd3,
		RegExtraTurnX = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		word_t shift_x;
		word_t shift_y;
		word_t shift_z;
		word_t size_factor;
	} geom_t;

	typedef struct packed {
		trig_t sin_x;
		trig_t cos_x;
		trig_t sin_y;
		trig_t cos_y;
		trig_t sin_z;
		trig_t cos_z;
	} trig_set_t;

	typedef struct packed {
		geom_t     geom;
		trig_set_t trig;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_beat_t;

	localparam acc_t RoundHalf = {{(ProdW - TrigFrac + 1){1'b0}}, 1'b1, {(TrigFrac - 1){1'b0}}};

	// round(16384 * sin(d)) for d = 0..90 degrees
	localparam logic [14:0] SinQ14 [91] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
		15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
		15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
		15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
		15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
		15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
		15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
		15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
		15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
		15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
		15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	// sine of a reduced angle 0..359 by quadrant folding
	function automatic trig_t sin_deg(input logic [AngW-1:0] a);
		logic [AngW-1:0] idx;
		logic            neg;
		logic [14:0]     mag;
		priority if (a <= QuarterTurn) begin
			idx = a;
			neg = 1'b0;
		end else if (a <= HalfTurn) begin
			idx = HalfTurn - a;
			neg = 1'b0;
		end else if (a <= ThreeQuart) begin
			idx = a - HalfTurn;
			neg = 1'b1;
		end else begin
			idx = FullTurn - a;
			neg = 1'b1;
		end
		mag = SinQ14[idx[6:0]];
		return neg ? -trig_t'({1'b0, mag}) : trig_t'({1'b0, mag});
	endfunction

	// cos(a) = sin(a + 90), wrapped back into 0..359
	function automatic trig_t cos_deg(input logic [AngW-1:0] a);
		logic [AngW-1:0] b;
		b = a + QuarterTurn;
		if (b >= FullTurn) begin
			b = b - FullTurn;
		end
		return sin_deg(b);
	endfunction

	// add half an lsb, then floor by 2^14 back to the coordinate format
	function automatic coord_t round_trig(input acc_t v);
		acc_t t;
		t = v + RoundHalf;
		return coord_t'(t[TrigFrac +: CoordW]);
	endfunction

endpackage

@@ hdl/cvet_front.sv @@
`timescale 1ns / 1ps
// front end: takes requests, reduces the three angles mod 360 and looks up sine and cosine
module cvet_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  cvet_pkg::word_t       shift_x,
	input  cvet_pkg::word_t       shift_y,
	input  cvet_pkg::word_t       shift_z,
	input  cvet_pkg::word_t       turn_x,
	input  cvet_pkg::word_t       turn_y,
	input  cvet_pkg::word_t       turn_z,
	input  cvet_pkg::word_t       size_factor,
	input  cvet_pkg::word_t       extra_turn_x,
	input  cvet_pkg::word_t       extra_turn_y,
	input  logic                  queue_full,
	output cvet_pkg::job_beat_t   push
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [cvet_pkg::BiasW-1:0]   turn_sum [3];
	logic [cvet_pkg::BiasW-1:0]   ang_s1   [3];
	logic [cvet_pkg::BiasW-1:0]   ang_s2   [3];
	logic [2*cvet_pkg::BiasW-1:0] prod     [3];
	logic [cvet_pkg::AngW-1:0]    quo_s2   [3];
	logic [cvet_pkg::BiasW-1:0]   rem_full [3];
	logic [cvet_pkg::AngW-1:0]    rem_s3   [3];

	cvet_pkg::geom_t     geom_s1, geom_s2, geom_s3, geom_s4;
	cvet_pkg::trig_set_t trig_s4;

	// sign-extended sum plus a whole number of turns, always positive
	function automatic logic [cvet_pkg::BiasW-1:0] biased_sum(
		input cvet_pkg::word_t a,
		input cvet_pkg::word_t b
	);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		return {s[16], s} + cvet_pkg::AngleBias;
	endfunction

	assign en       = !(v_s4 && queue_full);
	assign in_stall = !en;

	always_comb begin
		turn_sum[0] = biased_sum(turn_x, extra_turn_x);
		turn_sum[1] = biased_sum(turn_y, extra_turn_y);
		turn_sum[2] = biased_sum(turn_z, '0);
		for (int i = 0; i < 3; i++) begin
			prod[i]     = ang_s1[i] * cvet_pkg::RecipMul;
			rem_full[i] = ang_s2[i] - {{(cvet_pkg::BiasW - cvet_pkg::AngW){1'b0}}, quo_s2[i]}
				* cvet_pkg::FullTurnB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s1 <= '{shift_x: shift_x, shift_y: shift_y, shift_z: shift_z,
				size_factor: size_factor};
			geom_s2 <= geom_s1;
			geom_s3 <= geom_s2;
			geom_s4 <= geom_s3;
			for (int i = 0; i < 3; i++) begin
				ang_s1[i] <= turn_sum[i];
				ang_s2[i] <= ang_s1[i];
				quo_s2[i] <= prod[i][cvet_pkg::RecipShift +: cvet_pkg::AngW];
				rem_s3[i] <= rem_full[i][cvet_pkg::AngW-1:0];
			end
			trig_s4.sin_x <= cvet_pkg::sin_deg(rem_s3[0]);
			trig_s4.cos_x <= cvet_pkg::cos_deg(rem_s3[0]);
			trig_s4.sin_y <= cvet_pkg::sin_deg(rem_s3[1]);
			trig_s4.cos_y <= cvet_pkg::cos_deg(rem_s3[1]);
			trig_s4.sin_z <= cvet_pkg::sin_deg(rem_s3[2]);
			trig_s4.cos_z <= cvet_pkg::cos_deg(rem_s3[2]);
		end
	end

	assign push.valid    = v_s4 && !queue_full;
	assign push.job.geom = geom_s4;
	assign push.job.trig = trig_s4;

endmodule

@@ hdl/cvet_queue.sv @@
`timescale 1ns / 1ps
// short job queue between the front end and the corner engine
module cvet_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  cvet_pkg::job_beat_t push,
	output logic                full,
	output cvet_pkg::job_beat_t head,
	input  logic                pop
);

	localparam int PtrW = (cvet_pkg::QueueDepth > 1) ? $clog2(cvet_pkg::QueueDepth) : 1;
	localparam int CntW = $clog2(cvet_pkg::QueueDepth + 1);

	cvet_pkg::job_t   mem_q [cvet_pkg::QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_pop;

	assign full       = (count_q == CntW'(cvet_pkg::QueueDepth));
	assign head.valid = (count_q != '0);
	assign head.job   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(cvet_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

@@ hdl/cvet_back.sv @@
`timescale 1ns / 1ps
// corner engine: one corner a cycle when not stalled: scale, rotate x, y, z, offset, saturate
module cvet_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cvet_pkg::job_beat_t head,
	output logic                pop,
	input  cvet_pkg::word_t     offset_x,
	input  cvet_pkg::word_t     offset_y,
	input  cvet_pkg::word_t     offset_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          corner_index,
	output cvet_pkg::word_t     out_x,
	output cvet_pkg::word_t     out_y,
	output cvet_pkg::word_t     out_z,
	output logic                clipped,
	output logic                last_corner
);

	localparam int CW = cvet_pkg::CoordW;
	localparam logic signed [CW:0] SatMax = (CW + 1)'(32767);
	localparam logic signed [CW:0] SatMin = (CW + 1)'(-32768);

	logic en, issue;
	logic [2:0] cnt_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_valid_q;
	logic [2:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7;

	cvet_pkg::trig_set_t tr_s1, tr_s2, tr_s3, tr_s4, tr_s5;
	cvet_pkg::coord_t    x_s1, y_s1, z_s1;
	cvet_pkg::coord_t    x_s2, x_s3, y_s3, z_s3, y_s4, x_s5, y_s5, z_s5, z_s6, x_s7, y_s7, z_s7;
	cvet_pkg::prod_t     pa_s2, pb_s2, pc_s2, pd_s2;
	cvet_pkg::prod_t     pa_s4, pb_s4, pc_s4, pd_s4;
	cvet_pkg::prod_t     pa_s6, pb_s6, pc_s6, pd_s6;

	logic [16:0]     sat_x, sat_y, sat_z;
	logic [2:0]      idx_q;
	cvet_pkg::word_t ox_q, oy_q, oz_q;
	logic            clip_q, last_q;

	function automatic cvet_pkg::coord_t corner_coord(
		input logic            pos,
		input cvet_pkg::word_t size,
		input cvet_pkg::word_t shift
	);
		cvet_pkg::coord_t s;
		s = pos ? cvet_pkg::coord_t'(size) : -cvet_pkg::coord_t'(size);
		return s + cvet_pkg::coord_t'(shift);
	endfunction

	function automatic cvet_pkg::coord_t diff_rnd(input cvet_pkg::prod_t a, input cvet_pkg::prod_t b);
		return cvet_pkg::round_trig(cvet_pkg::acc_t'(a) - cvet_pkg::acc_t'(b));
	endfunction

	function automatic cvet_pkg::coord_t sum_rnd(input cvet_pkg::prod_t a, input cvet_pkg::prod_t b);
		return cvet_pkg::round_trig(cvet_pkg::acc_t'(a) + cvet_pkg::acc_t'(b));
	endfunction

	// {clip, value}
	function automatic logic [16:0] sat_add(input cvet_pkg::coord_t v, input cvet_pkg::word_t off);
		logic signed [CW:0] s;
		s = {v[CW-1], v} + {{(CW - 15){off[15]}}, off};
		priority if (s > SatMax) begin
			return {1'b1, 16'sh7fff};
		end else if (s < SatMin) begin
			return {1'b1, 16'sh8000};
		end else begin
			return {1'b0, s[15:0]};
		end
	endfunction

	assign en    = !(out_valid_q && out_stall);
	assign issue = head.valid && en;
	assign pop   = issue && (cnt_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1        <= head.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_comb begin
		sat_x = sat_add(x_s7, offset_x);
		sat_y = sat_add(y_s7, offset_y);
		sat_z = sat_add(z_s7, offset_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// corner from its index: x on bit 1, y on bit 2, z on bit 0 xor bit 1
			x_s1   <= corner_coord(cnt_q[1], head.job.geom.size_factor, head.job.geom.shift_x);
			y_s1   <= corner_coord(cnt_q[2], head.job.geom.size_factor, head.job.geom.shift_y);
			z_s1   <= corner_coord(cnt_q[0] ^ cnt_q[1], head.job.geom.size_factor,
				head.job.geom.shift_z);
			tr_s1  <= head.job.trig;
			idx_s1 <= cnt_q;

			// rotate about x
			pa_s2  <= y_s1 * tr_s1.cos_x;
			pb_s2  <= z_s1 * tr_s1.sin_x;
			pc_s2  <= y_s1 * tr_s1.sin_x;
			pd_s2  <= z_s1 * tr_s1.cos_x;
			x_s2   <= x_s1;
			tr_s2  <= tr_s1;
			idx_s2 <= idx_s1;

			y_s3   <= diff_rnd(pa_s2, pb_s2);
			z_s3   <= sum_rnd(pc_s2, pd_s2);
			x_s3   <= x_s2;
			tr_s3  <= tr_s2;
			idx_s3 <= idx_s2;

			// rotate about y
			pa_s4  <= z_s3 * tr_s3.cos_y;
			pb_s4  <= x_s3 * tr_s3.sin_y;
			pc_s4  <= z_s3 * tr_s3.sin_y;
			pd_s4  <= x_s3 * tr_s3.cos_y;
			y_s4   <= y_s3;
			tr_s4  <= tr_s3;
			idx_s4 <= idx_s3;

			z_s5   <= diff_rnd(pa_s4, pb_s4);
			x_s5   <= sum_rnd(pc_s4, pd_s4);
			y_s5   <= y_s4;
			tr_s5  <= tr_s4;
			idx_s5 <= idx_s4;

			// rotate about z
			pa_s6  <= x_s5 * tr_s5.cos_z;
			pb_s6  <= y_s5 * tr_s5.sin_z;
			pc_s6  <= x_s5 * tr_s5.sin_z;
			pd_s6  <= y_s5 * tr_s5.cos_z;
			z_s6   <= z_s5;
			idx_s6 <= idx_s5;

			x_s7   <= diff_rnd(pa_s6, pb_s6);
			y_s7   <= sum_rnd(pc_s6, pd_s6);
			z_s7   <= z_s6;
			idx_s7 <= idx_s6;

			// offset, saturate, hold for the consumer
			ox_q   <= sat_x[15:0];
			oy_q   <= sat_y[15:0];
			oz_q   <= sat_z[15:0];
			clip_q <= sat_x[16] | sat_y[16] | sat_z[16];
			idx_q  <= idx_s7;
			last_q <= (idx_s7 == 3'd7);
		end
	end

	assign out_valid    = out_valid_q;
	assign corner_index = idx_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign out_z        = oz_q;
	assign clipped      = clip_q;
	assign last_corner  = last_q;

endmodule

@@ hdl/cube_vertex_euler_transform.sv @@
`timescale 1ns / 1ps
// top level of the cube vertex transform: configuration registers and the front, queue and back
// Each accepted request beat (scale, shift and three whole-degree angles) yields eight result
// beats, one per unit-cube corner in the fixed order (-,-,-) (-,-,+) (+,-,+) (+,-,-) (-,+,-)
// (-,+,+) (+,+,+) (+,+,-), with last_corner high on the eighth. A corner is scaled and shifted,
// rotated about x, then y, then z with per-degree Q1.14 sine and cosine, then the global offset
// is added and each coordinate saturates to signed Q4.12, clipped flagging any saturation. The
// corner engine issues one corner per cycle while a job is queued and the output does not stall,
// and each request holds it for its eight corners. Requests are taken every cycle until the
// two-entry job queue and the four-stage angle front end are full, so a new request is usually
// already reduced and waiting when the previous one finishes. With the engine idle, the first
// corner beat of a request passes through the 4 front stages, the queue, the 7 engine stages
// and the output register. Output stall freezes the engine and its output register; input stall
// only rises when the queue is full and the front end holds a finished job. Configuration
// writes are taken every cycle (cfg_ready stays high); indices above 4 are ignored. The extra
// angles are added at request acceptance and the offsets at the end of the engine, so
// configuration must be changed only while no request is in flight; the block itself
// does not enforce it. There is no state besides these registers and no start-up pass.
module cube_vertex_euler_transform (
	input  logic            clk,
	input  logic            arst_n,
	// request channel
	input  logic            in_valid,
	output logic            in_stall,
	input  cvet_pkg::word_t shift_x,
	input  cvet_pkg::word_t shift_y,
	input  cvet_pkg::word_t shift_z,
	input  cvet_pkg::word_t turn_x,
	input  cvet_pkg::word_t turn_y,
	input  cvet_pkg::word_t turn_z,
	input  cvet_pkg::word_t size_factor,
	// corner channel
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      corner_index,
	output cvet_pkg::word_t out_x,
	output cvet_pkg::word_t out_y,
	output cvet_pkg::word_t out_z,
	output logic            clipped,
	output logic            last_corner,
	// configuration write channel
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	cvet_pkg::word_t offset_x_q, offset_y_q, offset_z_q;
	cvet_pkg::word_t extra_turn_y_q, extra_turn_x_q;

	cvet_pkg::job_beat_t push, head;
	logic                queue_full;
	logic                pop;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			offset_z_q     <= '0;
			extra_turn_y_q <= '0;
			extra_turn_x_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cvet_pkg::RegOffsetX:    offset_x_q     <= cfg_data;
				cvet_pkg::RegOffsetY:    offset_y_q     <= cfg_data;
				cvet_pkg::RegOffsetZ:    offset_z_q     <= cfg_data;
				cvet_pkg::RegExtraTurnY: extra_turn_y_q <= cfg_data;
				cvet_pkg::RegExtraTurnX: extra_turn_x_q <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// angle reduction and trig lookup
	cvet_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.shift_x      (shift_x),
		.shift_y      (shift_y),
		.shift_z      (shift_z),
		.turn_x       (turn_x),
		.turn_y       (turn_y),
		.turn_z       (turn_z),
		.size_factor  (size_factor),
		.extra_turn_x (extra_turn_x_q),
		.extra_turn_y (extra_turn_y_q),
		.queue_full   (queue_full),
		.push         (push)
	);

	// decouples the front end from the corner engine
	cvet_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	// eight corners per job, one per cycle while the output does not stall
	cvet_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.offset_x     (offset_x_q),
		.offset_y     (offset_y_q),
		.offset_z     (offset_z_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.corner_index (corner_index),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.clipped      (clipped),
		.last_corner  (last_corner)
	);

endmodule

@@ hdl/cvet_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the corner sequence of the cube vertex transform, bound to the top level
module cvet_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [2:0]      corner_index,
	input cvet_pkg::word_t out_x,
	input cvet_pkg::word_t out_y,
	input cvet_pkg::word_t out_z,
	input logic            clipped,
	input logic            last_corner
);

	logic [2:0] exp_idx_q;
	logic [4:0] pend_q;
	logic       in_beat, out_beat, done_beat;

	assign in_beat   = in_valid && !in_stall;
	assign out_beat  = out_valid && !out_stall;
	assign done_beat = out_beat && last_corner;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			pend_q    <= '0;
		end else begin
			if (out_beat) begin
				exp_idx_q <= exp_idx_q + 1'b1;
			end
			unique case ({in_beat, done_beat})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// corners come out in order, none skipped or repeated
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> corner_index == exp_idx_q)
		else $error("corner index out of sequence");

	// last flag marks exactly the eighth corner
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_corner == (corner_index == 3'd7))
		else $error("last_corner does not match corner index");

	// no corner without an accepted request still open
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("corner beat with no request outstanding");

	// a stalled corner beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(corner_index) && $stable(out_x)
			&& $stable(out_y) && $stable(out_z) && $stable(clipped))
		else $error("stalled corner beat changed");

endmodule

bind cube_vertex_euler_transform cvet_checker u_cvet_checker (.*);

@@ test/tb_cube_vertex_euler_transform.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the cube vertex euler transform, scoreboard class and drivers
module tb_cube_vertex_euler_transform;
	import cvet_pkg::*;

	typedef longint unsigned u64_t;

	// clock, reset and run length
	localparam int     HalfPeriodNs  = 6;
	localparam int     ResetCycles   = 10;
	localparam int     SettleCycles  = 40;     // well past the time from a request to its first corner
	localparam int     HoldCycles    = 400;    // long receiver hold-off, fills the block up
	localparam int     PhaseCount    = 7;
	localparam int     ItemsPerPhase = 68;
	localparam int     MaxReports    = 10;
	localparam longint RunLimitNs    = 5_000_000;

	// fixed-point constants of the predictor
	localparam u64_t   PiQ30        = 64'd3373259426;   // pi in Q30
	localparam int     TrigShift    = 14;
	localparam longint RoundHalfQ14 = 8192;
	localparam longint WordMax      = 32767;
	localparam longint WordMin      = -32768;

	// configuration indices past the register map, writes there are dropped
	localparam logic [2:0] FirstSpareReg = 3'd5;
	localparam logic [2:0] LastSpareReg  = 3'd7;

	typedef struct {
		word_t shift_x;
		word_t shift_y;
		word_t shift_z;
		word_t turn_x;
		word_t turn_y;
		word_t turn_z;
		word_t size_factor;
	} request_t;

	typedef struct {
		logic [2:0] index;
		word_t      x;
		word_t      y;
		word_t      z;
		logic       clip;
		logic       last;
	} corner_t;

	// predicts the eight corners of each request and checks corner beats in order
	class corner_scoreboard;
		corner_t expected_q[$];
		word_t   offset_x, offset_y, offset_z;
		word_t   extra_turn_x, extra_turn_y;
		longint  sine_lut [91];
		int      faults;

		// round(16384 * sin(d)) for d = 0..90, integer taylor series in Q30
		function new();
			u64_t arg, arg_sq, term, total, mag;
			offset_x     = '0;
			offset_y     = '0;
			offset_z     = '0;
			extra_turn_x = '0;
			extra_turn_y = '0;
			faults       = 0;
			for (int d = 0; d <= 90; d++) begin
				arg    = (u64_t'(d) * PiQ30) / 64'd180;
				arg_sq = (arg * arg) >> 30;
				term   = arg;
				total  = arg;
				for (int k = 1; k <= 12; k++) begin
					term = ((term * arg_sq) >> 30) / u64_t'((2 * k) * (2 * k + 1));
					if (k % 2 == 1) begin
						total = total - term;
					end else begin
						total = total + term;
					end
				end
				mag = (total + 64'd32768) >> 16;
				sine_lut[d] = (mag > 64'd16384) ? 64'sd16384 : longint'(mag);
			end
		endfunction

		function longint wrap_degrees(longint a);
			longint r;
			r = a % 360;
			if (r < 0) begin
				r += 360;
			end
			return r;
		endfunction

		// quadrant folding of the first-quadrant table
		function longint sine_q14(longint a);
			if (a <= 90) begin
				return sine_lut[a];
			end
			if (a <= 180) begin
				return sine_lut[180 - a];
			end
			if (a <= 270) begin
				return -sine_lut[a - 180];
			end
			return -sine_lut[360 - a];
		endfunction

		// add half an lsb, floor by 2^14
		function longint round_q14(longint v);
			return (v + RoundHalfQ14) >>> TrigShift;
		endfunction

		function word_t saturate(longint v, inout bit clip);
			if (v > WordMax) begin
				clip = 1'b1;
				return word_t'(WordMax);
			end
			if (v < WordMin) begin
				clip = 1'b1;
				return word_t'(WordMin);
			end
			return word_t'(v);
		endfunction

		function void write_reg(logic [2:0] index, logic [15:0] data);
			case (index)
				RegOffsetX:    offset_x = data;
				RegOffsetY:    offset_y = data;
				RegOffsetZ:    offset_z = data;
				RegExtraTurnY: extra_turn_y = data;
				RegExtraTurnX: extra_turn_x = data;
				default: ;
			endcase
		endfunction

		function void note_request(request_t r);
			longint  ax, ay, az;
			longint  sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
			longint  sc, px, py, pz, t;
			corner_t c;
			bit      clip;
			ax = wrap_degrees(longint'(r.turn_x) + longint'(extra_turn_x));
			ay = wrap_degrees(longint'(r.turn_y) + longint'(extra_turn_y));
			az = wrap_degrees(longint'(r.turn_z));
			sin_x = sine_q14(ax);
			cos_x = sine_q14(wrap_degrees(ax + 90));
			sin_y = sine_q14(ay);
			cos_y = sine_q14(wrap_degrees(ay + 90));
			sin_z = sine_q14(az);
			cos_z = sine_q14(wrap_degrees(az + 90));
			sc = longint'(r.size_factor);
			for (int i = 0; i < 8; i++) begin
				// corner order: x sign is bit 1, y sign bit 2, z sign bit 0 xor bit 1
				px = (i[1] ? sc : -sc) + longint'(r.shift_x);
				py = (i[2] ? sc : -sc) + longint'(r.shift_y);
				pz = ((i[0] ^ i[1]) ? sc : -sc) + longint'(r.shift_z);
				// about x
				t  = round_q14(py * cos_x - pz * sin_x);
				pz = round_q14(py * sin_x + pz * cos_x);
				py = t;
				// about y
				t  = round_q14(pz * cos_y - px * sin_y);
				px = round_q14(pz * sin_y + px * cos_y);
				pz = t;
				// about z
				t  = round_q14(px * cos_z - py * sin_z);
				py = round_q14(px * sin_z + py * cos_z);
				px = t;
				clip    = 1'b0;
				c.index = i[2:0];
				c.x     = saturate(px + longint'(offset_x), clip);
				c.y     = saturate(py + longint'(offset_y), clip);
				c.z     = saturate(pz + longint'(offset_z), clip);
				c.clip  = clip;
				c.last  = (i == 7);
				expected_q.push_back(c);
			end
		endfunction

		function void check_corner(corner_t got);
			corner_t want;
			if (expected_q.size() == 0) begin
				faults++;
				if (faults <= MaxReports) begin
					$display("corner beat with nothing expected: idx=%0d x=%0d y=%0d z=%0d",
						got.index, got.x, got.y, got.z);
				end
				return;
			end
			want = expected_q.pop_front();
			if (got.index !== want.index || got.x !== want.x || got.y !== want.y ||
				got.z !== want.z || got.clip !== want.clip || got.last !== want.last) begin
				faults++;
				if (faults <= MaxReports) begin
					$display("corner mismatch: expected idx=%0d x=%0d y=%0d z=%0d clip=%0b last=%0b",
						want.index, want.x, want.y, want.z, want.clip, want.last);
					$display("                 got      idx=%0d x=%0d y=%0d z=%0d clip=%0b last=%0b",
						got.index, got.x, got.y, got.z, got.clip, got.last);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// dut inputs, all known from time zero
	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	word_t      shift_x     = '0;
	word_t      shift_y     = '0;
	word_t      shift_z     = '0;
	word_t      turn_x      = '0;
	word_t      turn_y      = '0;
	word_t      turn_z      = '0;
	word_t      size_factor = '0;
	logic       out_stall   = 1'b0;
	logic       cfg_valid   = 1'b0;
	logic [2:0] cfg_index   = '0;
	logic [15:0] cfg_data   = '0;

	// dut outputs
	logic       in_stall;
	logic       out_valid;
	logic [2:0] corner_index;
	word_t      out_x;
	word_t      out_y;
	word_t      out_z;
	logic       clipped;
	logic       last_corner;
	logic       cfg_ready;

	corner_scoreboard sb;
	corner_t          corner_beat;

	// receiver pattern state, the long hold-off is requested by the stimulus
	int hold_cycles_req = 0;
	int hold_len        = 0;
	int spell_left      = 0;
	int stall_pct       = 0;

	cube_vertex_euler_transform u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.shift_x      (shift_x),
		.shift_y      (shift_y),
		.shift_z      (shift_z),
		.turn_x       (turn_x),
		.turn_y       (turn_y),
		.turn_z       (turn_z),
		.size_factor  (size_factor),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.corner_index (corner_index),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.clipped      (clipped),
		.last_corner  (last_corner),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#HalfPeriodNs;
		clk = 1'b1;
		#HalfPeriodNs;
	end

	// receiver: spells of random stall density, some with no stall at all,
	// or one long hold-off counted here while the sender keeps offering
	always begin
		@(posedge clk);
		if (hold_cycles_req != 0) begin
			hold_len        = hold_cycles_req;
			hold_cycles_req = 0;
			out_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
		end else begin
			if (spell_left == 0) begin
				spell_left = $urandom_range(8, 80);
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2:    stall_pct = 20;
					3:    stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			spell_left--;
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// corner beats, sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			corner_beat.index = corner_index;
			corner_beat.x     = out_x;
			corner_beat.y     = out_y;
			corner_beat.z     = out_z;
			corner_beat.clip  = clipped;
			corner_beat.last  = last_corner;
			sb.check_corner(corner_beat);
		end
	end

	// random value in -span..span
	function automatic int spread(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// extremes and near-extremes of a signed 16-bit field
	function automatic int edge_word();
		case ($urandom_range(10))
			0: return -32768;
			1: return -32767;
			2: return -16384;
			3: return -4096;
			4: return -1;
			5: return 0;
			6: return 1;
			7: return 4096;
			8: return 16383;
			9: return 32766;
			default: return 32767;
		endcase
	endfunction

	// angles on quadrant borders, around a full turn, negative and huge
	function automatic int angle_word();
		case ($urandom_range(20))
			0:  return 0;
			1:  return 1;
			2:  return 89;
			3:  return 90;
			4:  return 91;
			5:  return 179;
			6:  return 180;
			7:  return 181;
			8:  return 269;
			9:  return 270;
			10: return 271;
			11: return 359;
			12: return 360;
			13: return -1;
			14: return -90;
			15: return -180;
			16: return -359;
			17: return -360;
			18: return 32767;
			19: return -32768;
			default: return int'(word_t'($urandom));
		endcase
	endfunction

	function automatic request_t make_req(int sx, int sy, int sz, int tx, int ty, int tz, int sc);
		request_t r;
		r.shift_x     = word_t'(sx);
		r.shift_y     = word_t'(sy);
		r.shift_z     = word_t'(sz);
		r.turn_x      = word_t'(tx);
		r.turn_y      = word_t'(ty);
		r.turn_z      = word_t'(tz);
		r.size_factor = word_t'(sc);
		return r;
	endfunction

	// plausible cubes most often, then full-range noise, border angles and extremes
	function automatic request_t random_request();
		request_t r;
		int       mode;
		mode = $urandom_range(99);
		if (mode < 40) begin
			r = make_req(spread(8192), spread(8192), spread(8192),
				spread(400), spread(400), spread(400), spread(8192));
		end else if (mode < 70) begin
			r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (mode < 85) begin
			r = make_req(spread(8192), spread(8192), spread(8192),
				angle_word(), angle_word(), angle_word(), spread(8192));
		end else begin
			r = make_req(edge_word(), edge_word(), edge_word(),
				edge_word(), edge_word(), edge_word(), edge_word());
		end
		return r;
	endfunction

	// offer one request beat and hold it until taken
	task automatic offer_request(request_t r);
		in_valid    <= 1'b1;
		shift_x     <= r.shift_x;
		shift_y     <= r.shift_y;
		shift_z     <= r.shift_z;
		turn_x      <= r.turn_x;
		turn_y      <= r.turn_y;
		turn_z      <= r.turn_z;
		size_factor <= r.size_factor;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
	endtask

	task automatic idle_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender quiet until every corner is in, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// one configuration beat, valid stays up for the caller's next beat
	task automatic cfg_write(logic [2:0] index, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, data);
	endtask

	// all five registers plus one write past the map that must be dropped
	task automatic apply_setting(int ox, int oy, int oz, int ey, int ex);
		cfg_write(RegOffsetX, 16'(ox));
		cfg_write(RegOffsetY, 16'(oy));
		cfg_write(3'($urandom_range(FirstSpareReg, LastSpareReg)), 16'($urandom));
		cfg_write(RegOffsetZ, 16'(oz));
		cfg_write(RegExtraTurnY, 16'(ey));
		cfg_write(RegExtraTurnX, 16'(ex));
		cfg_valid <= 1'b0;
	endtask

	// random requests in bursts with random gaps; optionally a long receiver
	// hold-off with back-to-back offers, or a mid-phase pause until drained
	task automatic random_phase(int count, bit long_hold, bit mid_pause);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 24);
		for (int n = 0; n < count; n++) begin
			if (long_hold && n == count / 4) begin
				hold_cycles_req = HoldCycles;
			end
			offer_request(random_request());
			if (mid_pause && n == count / 2) begin
				drain_results();
			end else if (long_hold && n >= count / 4 && n < count / 4 + 40) begin
				// no gaps: keep the input pushing against the full block
			end else begin
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
					if (gap != 0) begin
						idle_sender(gap);
					end
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats with registers at their reset value
		offer_request(make_req(0, 0, 0, 0, 0, 0, 0));
		offer_request(make_req(0, 0, 0, 0, 0, 0, 4096));
		offer_request(make_req(4096, -4096, 2048, 90, 0, 0, 4096));
		offer_request(make_req(0, 0, 0, 0, 90, 0, 4096));
		offer_request(make_req(0, 0, 0, 0, 0, 90, 4096));
		offer_request(make_req(0, 0, 0, 180, 270, 360, 4096));
		offer_request(make_req(0, 0, 0, -1, -90, -180, 8192));
		offer_request(make_req(1000, 2000, 3000, 45, 45, 45, 8192));
		// huge angles, positive and negative, wrapped into one turn
		offer_request(make_req(0, 0, 0, 32767, -32768, 32767, 4096));
		offer_request(make_req(0, 0, 0, -32768, 32767, -32768, 4096));
		// field extremes, saturation on both sides
		offer_request(make_req(32767, 32767, 32767, 0, 0, 0, 32767));
		offer_request(make_req(-32768, -32768, -32768, 0, 0, 0, -32768));
		offer_request(make_req(-32768, -32768, -32768, 0, 0, 0, 32767));
		// wide intermediates through the rotation chain
		offer_request(make_req(32767, -32768, 32767, 45, 45, 45, 32767));
		offer_request(make_req(-32768, 32767, -32768, 135, 225, 315, -32768));
		offer_request(make_req(0, 0, 0, 30, 60, 89, -1));
		offer_request(make_req(1, -1, 1, 91, 179, 181, 1));
		offer_request(make_req(12345, -23456, 3456, 359, 269, 271, 20000));
		offer_request(make_req(-1, -1, -1, -1, -1, -1, -1));
		offer_request(make_req(16384, -16384, 0, 720, -720, 1080, 16384));
		drain_results();

		// register settings, extremes first, changed only while idle
		for (int phase = 1; phase <= PhaseCount; phase++) begin
			case (phase)
				1: apply_setting(32767, 32767, 32767, 32767, 32767);
				2: apply_setting(-32768, -32768, -32768, -32768, -32768);
				3: apply_setting(spread(4096), spread(4096), spread(4096), spread(360), spread(360));
				4: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom);
				5: apply_setting(0, 0, 0, 90, -90);
				6: apply_setting(-1, 1, 4096, 359, 360);
				default: apply_setting(0, 0, 0, 0, 0);
			endcase
			random_phase(ItemsPerPhase, phase == 2, phase == 3);
			drain_results();
		end

		if (sb.faults == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#RunLimitNs;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
